@@ sv/bbcd_pkg.sv @@
// Shared types and constants of the buffer cache directory.
package bbcd_pkg;

	// Default number of directory entries.
	localparam int ENTRIES_DEF = 32;

	// Largest reference count an entry can hold.
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		OP_GET     = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_COUNT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LOOKUP,
		S_UPDATE
	} state_t;

	// One directory entry as stored in the RAM.
	typedef struct packed {
		logic [31:0] dev;
		logic [31:0] blk;
		logic [7:0]  cnt;
		logic        dvalid;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Result of comparing one entry against the request.
	typedef struct packed {
		logic tag_eq;
		logic free;
	} match_t;

endpackage

@@ sv/bbcd_req_if.sv @@
// Request channel of the buffer cache directory.
interface bbcd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] device;
	logic [31:0] block_number;
	logic [4:0]  entry_index;

	modport source (output valid, op, device, block_number, entry_index, input ready);
	modport sink (input valid, op, device, block_number, entry_index, output ready);
endinterface

@@ sv/bbcd_rsp_if.sv @@
// Response channel of the buffer cache directory.
interface bbcd_rsp_if;
	logic       valid;
	logic       ready;
	logic [4:0] slot;
	logic       hit;
	logic       fill_needed;
	logic [1:0] status;

	modport source (output valid, slot, hit, fill_needed, status, input ready);
	modport sink (input valid, slot, hit, fill_needed, status, output ready);
endinterface

@@ sv/bbcd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bbcd_ram #(
	parameter int WIDTH = bbcd_pkg::ENTRY_W,
	parameter int DEPTH = bbcd_pkg::ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/bbcd_match.sv @@
// Shared compare unit: checks one entry for a tag match and for a free slot.
module bbcd_match (
	input  bbcd_pkg::entry_t word,
	input  logic [31:0]      dev,
	input  logic [31:0]      blk,
	output bbcd_pkg::match_t match
);

	// A tag hit needs both halves of the tag to agree.
	assign match.tag_eq = (word.dev == dev) && (word.blk == blk);
	assign match.free   = (word.cnt == 8'd0);

endmodule

@@ sv/block_buffer_cache_directory_core.sv @@
// Top level of the buffer cache directory: sequencer, entry RAM and valid bits.
//
// The directory keeps ENTRIES tagged entries (device, block, reference count,
// data valid) in one RAM that is read one entry per cycle. A get walks the
// entries in index order through a single compare unit, looking for a tag
// match while noting the lowest entry with no references; it stops at the
// first match. A get therefore reads the entries up to the matching one, or
// all ENTRIES of them on a miss, since there is one RAM read port and one
// compare unit. Release, pin and unpin read their entry once and write it
// back. The block takes one item at a time and is ready again in the cycle
// after its result is loaded into the output register; a waiting result
// does not stop a new item from being taken. Each entry has a reset-cleared
// written flag, so an entry never written reads as all zeros and no clearing
// pass is needed after reset.
module block_buffer_cache_directory_core #(
	parameter int ENTRIES = bbcd_pkg::ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bbcd_req_if.sink   req,
	bbcd_rsp_if.source rsp
);

	localparam int AW = $clog2(ENTRIES);

	// Sequencer state.
	bbcd_pkg::state_t state_q, state_d;

	// Latched request.
	bbcd_pkg::op_t op_q;
	logic [31:0]   dev_q;
	logic [31:0]   blk_q;
	logic [4:0]    idx_q;

	// Scan bookkeeping: issue counter, outstanding read and its tracking.
	logic [AW:0]      issue_q;
	logic             pend_s1;
	logic [AW-1:0]    pidx_s1;
	logic             init_s1;
	logic             hit_found_q;
	logic [AW-1:0]    hit_idx_q;
	bbcd_pkg::entry_t hit_word_q;
	logic             free_found_q;
	logic [AW-1:0]    free_idx_q;

	// One flag per entry: set once the entry has been written.
	logic [ENTRIES-1:0] init_q;

	// Output register.
	logic                rsp_valid_q;
	logic [4:0]          slot_q;
	logic                hit_q;
	logic                fill_q;
	bbcd_pkg::status_t   status_q;

	// RAM port signals.
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	bbcd_pkg::entry_t              ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [bbcd_pkg::ENTRY_W-1:0]  ram_rdata;

	// Entry as seen through the written flags, and the compare result.
	bbcd_pkg::entry_t rd_word;
	bbcd_pkg::match_t match;

	// Result being produced in the update step.
	logic              res_load;
	logic [4:0]        res_slot;
	logic              res_hit;
	logic              res_fill;
	bbcd_pkg::status_t res_status;

	logic          accept;
	logic          scan_hit;
	logic          idx_ok;
	logic [AW-1:0] idx_addr;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == bbcd_pkg::S_IDLE);

	assign rd_word  = init_s1 ? bbcd_pkg::entry_t'(ram_rdata) : '0;
	assign scan_hit = pend_s1 && match.tag_eq;

	// Release, pin and unpin on an entry past the table are ignored.
	assign idx_ok   = (32'(idx_q) < ENTRIES);
	assign idx_addr = AW'(idx_q);

	bbcd_ram #(
		.WIDTH(bbcd_pkg::ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bbcd_match u_match (
		.word (rd_word),
		.dev  (dev_q),
		.blk  (blk_q),
		.match(match)
	);

	// Next state, RAM control and the result of the update step.
	always_comb begin
		bbcd_pkg::entry_t cur;

		state_d    = state_q;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		res_load   = 1'b0;
		res_slot   = 5'(idx_q);
		res_hit    = 1'b0;
		res_fill   = 1'b0;
		res_status = bbcd_pkg::STAT_OK;
		cur        = '0;

		unique case (state_q)
			bbcd_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (bbcd_pkg::op_t'(req.op) == bbcd_pkg::OP_GET) ?
						bbcd_pkg::S_SCAN : bbcd_pkg::S_LOOKUP;
				end
			end
			bbcd_pkg::S_SCAN: begin
				// Keep reading ahead until a match turns up or the table ends.
				if (!scan_hit && (32'(issue_q) < ENTRIES)) begin
					ram_re    = 1'b1;
					ram_raddr = issue_q[AW-1:0];
				end
				if (scan_hit || (!pend_s1 && (32'(issue_q) >= ENTRIES))) begin
					state_d = bbcd_pkg::S_UPDATE;
				end
			end
			bbcd_pkg::S_LOOKUP: begin
				ram_re    = idx_ok;
				ram_raddr = idx_addr;
				state_d   = bbcd_pkg::S_UPDATE;
			end
			bbcd_pkg::S_UPDATE: begin
				// Write back and hand over the result once the output is free.
				res_load = !rsp_valid_q || rsp.ready;
				if (op_q == bbcd_pkg::OP_GET) begin
					if (hit_found_q) begin
						cur      = hit_word_q;
						res_slot = 5'(hit_idx_q);
						res_hit  = 1'b1;
						if (cur.cnt == bbcd_pkg::COUNT_MAX) begin
							res_status = bbcd_pkg::STAT_COUNT;
						end else begin
							res_fill  = !cur.dvalid;
							ram_we    = res_load;
							ram_waddr = hit_idx_q;
							ram_wdata = '{dev: cur.dev, blk: cur.blk,
								cnt: cur.cnt + 8'd1, dvalid: 1'b1};
						end
					end else if (free_found_q) begin
						// Claim the lowest free entry; it must be filled.
						res_slot  = 5'(free_idx_q);
						res_fill  = 1'b1;
						ram_we    = res_load;
						ram_waddr = free_idx_q;
						ram_wdata = '{dev: dev_q, blk: blk_q, cnt: 8'd1, dvalid: 1'b1};
					end else begin
						res_slot   = '0;
						res_status = bbcd_pkg::STAT_FULL;
					end
				end else if (idx_ok) begin
					cur       = rd_word;
					ram_waddr = idx_addr;
					if (op_q == bbcd_pkg::OP_PIN) begin
						if (cur.cnt == bbcd_pkg::COUNT_MAX) begin
							res_status = bbcd_pkg::STAT_COUNT;
						end else begin
							ram_we    = res_load;
							ram_wdata = '{dev: cur.dev, blk: cur.blk,
								cnt: cur.cnt + 8'd1, dvalid: cur.dvalid};
						end
					end else begin
						if (cur.cnt == 8'd0) begin
							res_status = bbcd_pkg::STAT_COUNT;
						end else begin
							ram_we    = res_load;
							ram_wdata = '{dev: cur.dev, blk: cur.blk,
								cnt: cur.cnt - 8'd1, dvalid: cur.dvalid};
						end
					end
				end
				if (res_load) begin
					state_d = bbcd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bbcd_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbcd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers of the scan and the written flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q      <= '0;
			pend_s1      <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			init_q       <= '0;
		end else begin
			if (accept) begin
				issue_q      <= '0;
				pend_s1      <= 1'b0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				pend_s1 <= ram_re;
				if (ram_re) begin
					issue_q <= issue_q + 1'b1;
				end
				if (state_q == bbcd_pkg::S_SCAN && pend_s1) begin
					if (match.tag_eq) begin
						hit_found_q <= 1'b1;
					end else if (match.free) begin
						free_found_q <= 1'b1;
					end
				end
			end
			if (ram_we) begin
				init_q[ram_waddr] <= 1'b1;
			end
		end
	end

	// Payload registers of the request and of the scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= bbcd_pkg::op_t'(req.op);
			dev_q <= req.device;
			blk_q <= req.block_number;
			idx_q <= req.entry_index;
		end
		if (ram_re) begin
			pidx_s1 <= ram_raddr;
			init_s1 <= init_q[ram_raddr];
		end
		if (state_q == bbcd_pkg::S_SCAN && scan_hit) begin
			hit_idx_q  <= pidx_s1;
			hit_word_q <= rd_word;
		end
		if (state_q == bbcd_pkg::S_SCAN && pend_s1 && !match.tag_eq && match.free
			&& !free_found_q) begin
			free_idx_q <= pidx_s1;
		end
	end

	// Output register: the result waits here until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			slot_q   <= res_slot;
			hit_q    <= res_hit;
			fill_q   <= res_fill;
			status_q <= res_status;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.slot        = slot_q;
	assign rsp.hit         = hit_q;
	assign rsp.fill_needed = fill_q;
	assign rsp.status      = status_q;

	// An accepted item always leaves the idle state on the next edge.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != bbcd_pkg::S_IDLE)
		else $error("accepted item did not start the sequencer");

	// A fresh result only appears after the update step.
	a_rsp_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == bbcd_pkg::S_UPDATE))
		else $error("result appeared outside the update step");

	// A full table reports slot zero with no hit and no fill.
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == bbcd_pkg::STAT_FULL) |->
		(slot_q == 5'd0 && !hit_q && !fill_q))
		else $error("full-table result carries a slot, hit or fill");

	// The RAM is written only when the result is handed over.
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> rsp_valid_q)
		else $error("entry written without a result");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the buffer cache directory: stimulus, prediction and checking.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ENTRIES = bbcd_pkg::ENTRIES_DEF;
	// Size of the tag pool that most gets draw from. It is larger than the
	// table so that the table can fill up and entries get retagged.
	localparam int POOL_SIZE = 40;
	// Cycles without any accepted item before the run is declared hung.
	// The worst legal gap is the long receiver hold-off plus one full miss
	// scan plus idle streaks, all far below this.
	localparam int HANG_LIMIT = 3000;
	// Length of the receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES = 300;

	// One request item as it crosses the request channel.
	typedef struct packed {
		bbcd_pkg::op_t op;
		logic [31:0]   device;
		logic [31:0]   block_number;
		logic [4:0]    entry_index;
	} dir_req_t;

	// One response item as it crosses the response channel.
	typedef struct packed {
		logic [4:0]        slot;
		logic              hit;
		logic              fill_needed;
		bbcd_pkg::status_t status;
	} dir_rsp_t;

	// The scoreboard keeps a private copy of the directory. Every accepted
	// request is applied to that copy and the response it must produce is
	// queued; every accepted response is compared with the oldest one queued.
	class directory_scoreboard;
		logic [31:0] tag_dev [N_ENTRIES];
		logic [31:0] tag_blk [N_ENTRIES];
		logic [7:0]  refs    [N_ENTRIES];
		bit          filled  [N_ENTRIES];
		dir_rsp_t    awaited [$];
		int          errors;

		function new();
			for (int i = 0; i < N_ENTRIES; i++) begin
				tag_dev[i] = '0;
				tag_blk[i] = '0;
				refs[i]    = '0;
				filled[i]  = 1'b0;
			end
			errors = 0;
		endfunction

		// Applies one request to the directory copy and returns its response.
		function dir_rsp_t apply_request(dir_req_t r);
			dir_rsp_t res;
			int       found;
			int       idx;
			res.slot        = r.entry_index;
			res.hit         = 1'b0;
			res.fill_needed = 1'b0;
			res.status      = bbcd_pkg::STAT_OK;
			if (r.op == bbcd_pkg::OP_GET) begin
				found = -1;
				for (int i = 0; i < N_ENTRIES; i++)
					if (found < 0 && tag_dev[i] == r.device && tag_blk[i] == r.block_number)
						found = i;
				if (found >= 0) begin
					res.slot = 5'(found);
					res.hit  = 1'b1;
					if (refs[found] == bbcd_pkg::COUNT_MAX) begin
						res.status = bbcd_pkg::STAT_COUNT;
					end else begin
						refs[found]++;
						res.fill_needed = !filled[found];
						filled[found]   = 1'b1;
					end
				end else begin
					for (int i = 0; i < N_ENTRIES; i++)
						if (found < 0 && refs[i] == 8'd0)
							found = i;
					if (found >= 0) begin
						// A claimed entry is retagged and always needs a fill.
						tag_dev[found]  = r.device;
						tag_blk[found]  = r.block_number;
						refs[found]     = 8'd1;
						filled[found]   = 1'b1;
						res.slot        = 5'(found);
						res.fill_needed = 1'b1;
					end else begin
						res.slot   = '0;
						res.status = bbcd_pkg::STAT_FULL;
					end
				end
			end else begin
				idx = r.entry_index;
				if (idx < N_ENTRIES) begin
					if (r.op == bbcd_pkg::OP_PIN) begin
						if (refs[idx] == bbcd_pkg::COUNT_MAX)
							res.status = bbcd_pkg::STAT_COUNT;
						else
							refs[idx]++;
					end else begin
						if (refs[idx] == 8'd0)
							res.status = bbcd_pkg::STAT_COUNT;
						else
							refs[idx]--;
					end
				end
			end
			return res;
		endfunction

		function void note_request(dir_req_t r);
			awaited.push_back(apply_request(r));
		endfunction

		function void check_response(dir_rsp_t got);
			dir_rsp_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display({"%0t: response with no request pending: ",
						"slot %0d hit %0b fill %0b status %0d"},
						$realtime, got.slot, got.hit, got.fill_needed, got.status);
				return;
			end
			want = awaited.pop_front();
			if (got.slot !== want.slot || got.hit !== want.hit ||
					got.fill_needed !== want.fill_needed || got.status !== want.status) begin
				errors++;
				if (errors <= 10)
					$display({"%0t: mismatch: expected slot %0d hit %0b fill %0b status %0d, ",
						"got slot %0d hit %0b fill %0b status %0d"},
						$realtime, want.slot, want.hit, want.fill_needed, want.status,
						got.slot, got.hit, got.fill_needed, got.status);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bbcd_req_if req_ch ();
	bbcd_rsp_if rsp_ch ();

	block_buffer_cache_directory_core #(
		.ENTRIES(N_ENTRIES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	directory_scoreboard sb;

	// Idle rates in percent for the sender and the receiver, changed per phase.
	int tx_idle_pct;
	int rx_idle_pct;
	// Set by the stimulus to ask the receiver for one long hold-off.
	bit rx_hold_pending;
	// Number of request items accepted so far.
	int items_sent;

	logic [31:0] pool_dev [POOL_SIZE];
	logic [31:0] pool_blk [POOL_SIZE];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Most gets draw from the tag pool so that hits are common; the rest use
	// fresh random tags, which almost always miss.
	function automatic void random_tag(output logic [31:0] dev, output logic [31:0] blk);
		int p;
		if ($urandom_range(99) < 70) begin
			p   = $urandom_range(POOL_SIZE - 1);
			dev = pool_dev[p];
			blk = pool_blk[p];
		end else begin
			dev = $urandom;
			blk = $urandom;
		end
	endfunction

	// Picks an entry that currently holds references, so that most releases
	// and unpins succeed; now and then any entry, which may underflow.
	function automatic logic [4:0] busy_entry();
		int busy [$];
		for (int i = 0; i < N_ENTRIES; i++)
			if (sb.refs[i] != 8'd0)
				busy.push_back(i);
		if (busy.size() == 0 || $urandom_range(99) < 15)
			return 5'($urandom_range(N_ENTRIES - 1));
		return 5'(busy[$urandom_range(busy.size() - 1)]);
	endfunction

	function automatic int free_entries();
		int n;
		n = 0;
		for (int i = 0; i < N_ENTRIES; i++)
			if (sb.refs[i] == 8'd0)
				n++;
		return n;
	endfunction

	// One item of the everyday mix. Gets and reference drops are balanced so
	// that the table neither stays empty nor stays full; a tenth is noise
	// with every field random.
	function automatic dir_req_t mixed_item();
		dir_req_t r;
		int       k;
		k = $urandom_range(99);
		r.entry_index = 5'($urandom);
		random_tag(r.device, r.block_number);
		if (k < 40) begin
			r.op = bbcd_pkg::OP_GET;
		end else if (k < 80) begin
			r.op          = $urandom_range(1) ? bbcd_pkg::OP_RELEASE : bbcd_pkg::OP_UNPIN;
			r.entry_index = busy_entry();
		end else if (k < 90) begin
			r.op = bbcd_pkg::OP_PIN;
		end else begin
			r.op           = bbcd_pkg::op_t'($urandom_range(3));
			r.device       = $urandom;
			r.block_number = $urandom;
		end
		return r;
	endfunction

	// Offers one item and returns at the falling edge after it is accepted.
	// It is always entered at a falling edge, so valid gets exactly one
	// assignment per time step whether the next item follows back to back
	// or after an idle cycle.
	task automatic send_req(input dir_req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= r.op;
		req_ch.device       <= r.device;
		req_ch.block_number <= r.block_number;
		req_ch.entry_index  <= r.entry_index;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_op(input bbcd_pkg::op_t op, input logic [31:0] dev,
			input logic [31:0] blk, input logic [4:0] idx);
		dir_req_t r;
		r.op           = op;
		r.device       = dev;
		r.block_number = blk;
		r.entry_index  = idx;
		send_req(r);
	endtask

	// The sender stops offering and waits until every response has arrived.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
	endtask

	// A phase of random traffic: mostly runs of the everyday mix, and now
	// and then a sequence that fills the table with fresh tags, runs gets
	// into the full table and then drops references again.
	task automatic run_phase(input int target);
		int       start;
		int       guard;
		dir_req_t r;
		start = items_sent;
		while (items_sent - start < target) begin
			if ($urandom_range(99) < 8) begin
				guard = 0;
				while (free_entries() != 0 && guard < N_ENTRIES + 4) begin
					send_op(bbcd_pkg::OP_GET, $urandom, $urandom, 5'($urandom));
					guard++;
				end
				repeat (2) begin
					r.op          = bbcd_pkg::OP_GET;
					r.entry_index = 5'($urandom);
					random_tag(r.device, r.block_number);
					send_req(r);
				end
				repeat (N_ENTRIES / 2)
					send_op($urandom_range(1) ? bbcd_pkg::OP_RELEASE : bbcd_pkg::OP_UNPIN,
						$urandom, $urandom, busy_entry());
			end else begin
				repeat ($urandom_range(20, 50))
					send_req(mixed_item());
			end
		end
	endtask

	// Main stimulus: reset, directed items, then three phases of random
	// traffic with different idle rates, and the final check.
	initial begin
		int          e;
		int          j;
		logic [7:0]  base;
		logic [31:0] all1;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.op           = bbcd_pkg::OP_GET;
		req_ch.device       = '0;
		req_ch.block_number = '0;
		req_ch.entry_index  = '0;
		tx_idle_pct         = 26;
		rx_idle_pct         = 49;
		rx_hold_pending     = 1'b0;
		items_sent          = 0;
		all1                = '1;
		sb                  = new();

		// The pool holds the all-zero and all-one tags, random tags, and
		// tags that share a device with an earlier one so that a match on
		// the device alone is not taken for a hit.
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_dev[i] = (i >= 20) ? pool_dev[i - 18] : $urandom;
			pool_blk[i] = $urandom;
		end
		pool_dev[0] = '0;
		pool_blk[0] = '0;
		pool_dev[1] = '1;
		pool_blk[1] = '1;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. All tags are zero after reset, so the first get of
		// device 0, block 0 hits entry 0 and still asks for a fill.
		send_op(bbcd_pkg::OP_GET, '0, '0, 5'd0);
		send_op(bbcd_pkg::OP_GET, '0, '0, 5'd31);
		// An all-ones tag misses and claims the lowest free entry.
		send_op(bbcd_pkg::OP_GET, all1, all1, 5'd0);
		send_op(bbcd_pkg::OP_GET, all1, all1, 5'd31);
		// Drop entry 0 to zero, then once more for an underflow.
		send_op(bbcd_pkg::OP_RELEASE, '0, '0, 5'd0);
		send_op(bbcd_pkg::OP_UNPIN, '0, '0, 5'd0);
		send_op(bbcd_pkg::OP_UNPIN, '0, '0, 5'd0);
		// The highest entry: underflow, pin, unpin, pin, release.
		send_op(bbcd_pkg::OP_RELEASE, all1, all1, 5'd31);
		send_op(bbcd_pkg::OP_PIN, all1, all1, 5'd31);
		send_op(bbcd_pkg::OP_UNPIN, '0, '0, 5'd31);
		send_op(bbcd_pkg::OP_PIN, '0, '0, 5'd31);
		send_op(bbcd_pkg::OP_RELEASE, '0, '0, 5'd31);
		// A hit on an entry that holds no references and already has data.
		send_op(bbcd_pkg::OP_GET, '0, '0, 5'd0);
		send_op(bbcd_pkg::OP_GET, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd21);
		send_op(bbcd_pkg::OP_GET, '0, all1, 5'd10);
		send_op(bbcd_pkg::OP_GET, all1, '0, 5'd5);
		send_op(bbcd_pkg::OP_GET, 32'h8000_0001, 32'h0000_0001, 5'd16);
		send_op(bbcd_pkg::OP_UNPIN, '0, '0, 5'd2);
		send_op(bbcd_pkg::OP_GET, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd0);
		send_op(bbcd_pkg::OP_PIN, '0, '0, 5'd1);

		// Phase one: the receiver idles more than the sender, and once holds
		// off long enough for the block to back up into its input.
		rx_hold_pending = 1'b1;
		run_phase(250);
		drain();

		tx_idle_pct = 49;
		rx_idle_pct = 26;
		run_phase(250);
		drain();

		// Phase three: no idling, another long hold-off, then one entry is
		// pinned up to its count limit, pinned past it, hit by a get at the
		// limit, and brought back down.
		tx_idle_pct     = 0;
		rx_idle_pct     = 0;
		rx_hold_pending = 1'b1;
		run_phase(100);
		e = $urandom_range(N_ENTRIES - 1);
		j = e;
		for (int i = N_ENTRIES - 1; i >= 0; i--)
			if (sb.tag_dev[i] == sb.tag_dev[e] && sb.tag_blk[i] == sb.tag_blk[e])
				j = i;
		base = sb.refs[j];
		while (sb.refs[j] != bbcd_pkg::COUNT_MAX)
			send_op(bbcd_pkg::OP_PIN, $urandom, $urandom, 5'(j));
		repeat (2)
			send_op(bbcd_pkg::OP_PIN, $urandom, $urandom, 5'(j));
		send_op(bbcd_pkg::OP_GET, sb.tag_dev[j], sb.tag_blk[j], 5'($urandom));
		while (sb.refs[j] > base)
			send_op($urandom_range(1) ? bbcd_pkg::OP_RELEASE : bbcd_pkg::OP_UNPIN,
				$urandom, $urandom, 5'(j));
		drain();

		// A get with a miss scans the whole table; give any stray response
		// time to show up before the verdict.
		repeat (2 * N_ENTRIES + 8) @(posedge clk);
		sb.errors += sb.awaited.size();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: ready changes at the falling edge. A requested hold-off is
	// counted here, independent of what the sender does meanwhile.
	initial begin
		int hold_left;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_pending) begin
				rx_hold_pending = 1'b0;
				hold_left       = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Both channels are observed at the rising edge. A request is noted
	// before a response is checked; a response never belongs to a request
	// accepted at the same edge.
	always @(posedge clk) begin : channel_monitor
		dir_req_t seen_req;
		dir_rsp_t seen_rsp;
		if (arst_n === 1'b1) begin
			if (req_ch.valid && req_ch.ready) begin
				seen_req.op           = bbcd_pkg::op_t'(req_ch.op);
				seen_req.device       = req_ch.device;
				seen_req.block_number = req_ch.block_number;
				seen_req.entry_index  = req_ch.entry_index;
				sb.note_request(seen_req);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen_rsp.slot        = rsp_ch.slot;
				seen_rsp.hit         = rsp_ch.hit;
				seen_rsp.fill_needed = rsp_ch.fill_needed;
				seen_rsp.status      = bbcd_pkg::status_t'(rsp_ch.status);
				sb.check_response(seen_rsp);
			end
		end
	end

	// Watchdog: ends the run if no item moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item accepted for %0d cycles", $realtime, HANG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
sv/bbcd_pkg.sv
sv/bbcd_req_if.sv
sv/bbcd_rsp_if.sv
sv/bbcd_ram.sv
sv/bbcd_match.sv
sv/block_buffer_cache_directory_core.sv
tb/tb_top.sv
